// ===== rtl/core/a2rm_pkg.sv =====
// Shared types, widths and constants for the axis-angle to rotation matrix pipeline.
// No dependencies; every module of the block imports this package.
package a2rm_pkg;

   // Field widths.
   localparam int ANGLE_W = 18;
   localparam int AXIS_W  = 16;
   localparam int ENT_W   = 16;

   // Internal datapath widths.
   localparam int RED_W   = 36;   // Q30 angle before reduction
   localparam int QCNT_W  = 4;    // signed quarter-turn count, -5 to 5
   localparam int XY_W    = 33;   // CORDIC x and y, Q30
   localparam int Z_W     = 32;   // CORDIC residual angle, Q30
   localparam int C20_W   = 22;   // sine and cosine rounded to Q20
   localparam int V20_W   = 23;   // versine in Q20
   localparam int UU_W    = 32;   // axis products, Q28
   localparam int PUV_W   = 55;   // axis product times versine, Q48
   localparam int PUS_W   = 38;   // axis component times sine, Q34
   localparam int SUM_W   = 58;   // matrix entry before rounding, Q48
   localparam int RND_W   = 24;   // matrix entry rounded to Q14, before saturation

   localparam int ATAN_LEN     = 24;
   localparam int REDUCE_STEPS = 5;

   localparam logic signed [RED_W-1:0] Q30_QUARTER_PI = 36'sd843314857;
   localparam logic signed [RED_W-1:0] Q30_HALF_PI    = 36'sd1686629713;
   localparam logic signed [XY_W-1:0]  Q30_GAIN       = 33'sd652032874;

   // Quarter-pi plus j half-pi steps; the count of steps passed is the quadrant.
   localparam logic signed [RED_W-1:0] REDUCE_THR [REDUCE_STEPS] = '{
      36'sd843314857, 36'sd2529944570, 36'sd4216574283,
      36'sd5903203996, 36'sd7589833709
   };

   // Truncated Q30 arctangent of 2^-i.
   localparam logic signed [Z_W-1:0] ATAN_TAB [ATAN_LEN] = '{
      32'sh3243F6A8, 32'sh1DAC6705, 32'sh0FADBAFC, 32'sh07F56EA6, 32'sh03FEAB76,
      32'sh01FFD55B, 32'sh00FFFAAA, 32'sh007FFF55, 32'sh003FFFEA, 32'sh001FFFFD,
      32'sh000FFFFF, 32'sh0007FFFF, 32'sh0003FFFF, 32'sh0001FFFF, 32'sh0000FFFF,
      32'sh00007FFF, 32'sh00003FFF, 32'sh00001FFF, 32'sh00000FFF, 32'sh000007FF,
      32'sh000003FF, 32'sh000001FF, 32'sh000000FF, 32'sh0000007F
   };

   localparam logic signed [ENT_W-1:0] ENT_MAX = 16'sd16384;
   localparam logic signed [ENT_W-1:0] ENT_MIN = -16'sd16384;

   typedef enum logic [1:0] {
      QUAD_0,
      QUAD_90,
      QUAD_180,
      QUAD_270
   } quad_type;

   typedef struct packed {
      logic signed [AXIS_W-1:0] x;
      logic signed [AXIS_W-1:0] y;
      logic signed [AXIS_W-1:0] z;
   } axis_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      quad_type               quad;
      axis_type               axis;
   } cordic_type;

endpackage

// ===== rtl/core/a2rm_reduce.sv =====
// Angle range reduction: two pipeline stages that split the angle into a quadrant and a
// residual within plus or minus pi/4. Depends on a2rm_pkg.
module a2rm_reduce (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [a2rm_pkg::ANGLE_W-1:0] angle,
   input  a2rm_pkg::axis_type                  axis,
   output logic                                out_valid,
   input  logic                                out_ready,
   output a2rm_pkg::cordic_type                out_data
);
   import a2rm_pkg::*;

   logic                      s1_valid_ff, s1_valid_in, s1_ready;
   logic signed [ANGLE_W-1:0] s1_angle_ff;
   logic signed [QCNT_W-1:0]  s1_quad_ff, s1_quad_in;
   axis_type                  s1_axis_ff;

   logic                      s2_valid_ff, s2_valid_in, s2_ready;
   cordic_type                s2_data_ff, s2_data_in;

   logic signed [RED_W-1:0]   z_wide;
   logic [2:0]                cnt_pos, cnt_neg;
   logic signed [RED_W-1:0]   s2_z_wide;
   logic signed [Z_W-1:0]     residual;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // Stage one counts the quarter turns that the angle lies beyond.
   always_comb begin
      z_wide  = RED_W'(angle) <<< 16;
      cnt_pos = '0;
      cnt_neg = '0;
      for (int j = 0; j < REDUCE_STEPS; j++) begin
         cnt_pos = cnt_pos + 3'(z_wide > REDUCE_THR[j]);
         cnt_neg = cnt_neg + 3'(z_wide < -REDUCE_THR[j]);
      end
      s1_quad_in  = QCNT_W'(cnt_pos) - QCNT_W'(cnt_neg);
      s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
   end

   // Stage two removes the quarter turns and seeds the rotation.
   always_comb begin
      s2_z_wide  = RED_W'(s1_angle_ff) <<< 16;
      residual   = Z_W'(s2_z_wide - RED_W'(s1_quad_ff) * Q30_HALF_PI);
      s2_data_in.x    = Q30_GAIN;
      s2_data_in.y    = '0;
      s2_data_in.z    = residual;
      s2_data_in.quad = quad_type'(s1_quad_ff[1:0]);
      s2_data_in.axis = s1_axis_ff;
      s2_valid_in     = s2_ready ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_angle_ff <= angle;
         s1_quad_ff  <= s1_quad_in;
         s1_axis_ff  <= axis;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

// ===== rtl/core/a2rm_cordic_stage.sv =====
// One rotation-mode CORDIC micro-rotation with its pipeline register.
// Depends on a2rm_pkg.
module a2rm_cordic_stage #(
   parameter int SHIFT = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  a2rm_pkg::cordic_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output a2rm_pkg::cordic_type out_data
);
   import a2rm_pkg::*;

   logic                   valid_ff, valid_in;
   cordic_type             data_ff, data_in;
   logic signed [XY_W-1:0] x_cur, y_cur, xs, ys;
   logic signed [Z_W-1:0]  z_cur;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      x_cur   = in_data.x;
      y_cur   = in_data.y;
      z_cur   = in_data.z;
      xs      = x_cur >>> SHIFT;
      ys      = y_cur >>> SHIFT;
      data_in = in_data;
      if (!z_cur[Z_W-1]) begin
         data_in.x = x_cur - ys;
         data_in.y = y_cur + xs;
         data_in.z = z_cur - ATAN_TAB[SHIFT];
      end else begin
         data_in.x = x_cur + ys;
         data_in.y = y_cur - xs;
         data_in.z = z_cur + ATAN_TAB[SHIFT];
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/core/a2rm_matrix.sv =====
// Rodrigues matrix assembly: quadrant fold, products, sums and saturation in four
// pipeline stages; the last stage is the result register. Depends on a2rm_pkg.
module a2rm_matrix (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  a2rm_pkg::cordic_type              in_data,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic signed [a2rm_pkg::ENT_W-1:0] ent [9]
);
   import a2rm_pkg::*;

   localparam int XX = 0;
   localparam int YY = 1;
   localparam int ZZ = 2;
   localparam int XY = 3;
   localparam int XZ = 4;
   localparam int YZ = 5;
   localparam int AX = 0;
   localparam int AY = 1;
   localparam int AZ = 2;

   localparam logic signed [V20_W-1:0] ONE_Q20   = 23'sd1048576;
   localparam logic signed [SUM_W-1:0] ROUND_Q48 = 58'sd8589934592;

   logic [3:0] valid_ff, valid_in, ready;

   // Stage one: sine, cosine, versine and axis products.
   logic signed [XY_W-1:0]   c_sel, s_sel;
   logic signed [C20_W-1:0]  c20_in, s20_in, s1_c20_ff, s1_s20_ff;
   logic signed [V20_W-1:0]  v20_in, s1_v20_ff;
   logic signed [UU_W-1:0]   uu_in [6];
   logic signed [UU_W-1:0]   uu_ff [6];
   logic signed [AXIS_W-1:0] s1_u_ff [3];

   // Stage two: products with versine and sine.
   logic signed [PUV_W-1:0]  puv_in [6];
   logic signed [PUV_W-1:0]  puv_ff [6];
   logic signed [PUS_W-1:0]  pus_in [3];
   logic signed [PUS_W-1:0]  pus_ff [3];
   logic signed [C20_W-1:0]  s2_c20_ff;

   // Stage three: entry sums; stage four: rounded and saturated entries.
   logic signed [SUM_W-1:0]  cd, sk_x, sk_y, sk_z;
   logic signed [SUM_W-1:0]  sum_in [9];
   logic signed [SUM_W-1:0]  sum_ff [9];
   logic signed [RND_W-1:0]  rnd;
   logic signed [ENT_W-1:0]  ent_in [9];
   logic signed [ENT_W-1:0]  ent_ff [9];

   assign ready[3] = !valid_ff[3] || out_ready;
   assign ready[2] = !valid_ff[2] || ready[3];
   assign ready[1] = !valid_ff[1] || ready[2];
   assign ready[0] = !valid_ff[0] || ready[1];
   assign in_ready = ready[0];

   always_comb begin
      valid_in[0] = ready[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < 4; k++) begin
         valid_in[k] = ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_comb begin
      case (in_data.quad)
         QUAD_90: begin
            c_sel = -in_data.y;
            s_sel = in_data.x;
         end
         QUAD_180: begin
            c_sel = -in_data.x;
            s_sel = -in_data.y;
         end
         QUAD_270: begin
            c_sel = in_data.y;
            s_sel = -in_data.x;
         end
         default: begin
            c_sel = in_data.x;
            s_sel = in_data.y;
         end
      endcase
      c20_in = C20_W'((34'(c_sel) + 34'sd512) >>> 10);
      s20_in = C20_W'((34'(s_sel) + 34'sd512) >>> 10);
      v20_in = ONE_Q20 - V20_W'(c20_in);
      uu_in[XX] = UU_W'(in_data.axis.x) * UU_W'(in_data.axis.x);
      uu_in[YY] = UU_W'(in_data.axis.y) * UU_W'(in_data.axis.y);
      uu_in[ZZ] = UU_W'(in_data.axis.z) * UU_W'(in_data.axis.z);
      uu_in[XY] = UU_W'(in_data.axis.x) * UU_W'(in_data.axis.y);
      uu_in[XZ] = UU_W'(in_data.axis.x) * UU_W'(in_data.axis.z);
      uu_in[YZ] = UU_W'(in_data.axis.y) * UU_W'(in_data.axis.z);
   end

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         puv_in[k] = PUV_W'(uu_ff[k]) * PUV_W'(s1_v20_ff);
      end
      for (int a = 0; a < 3; a++) begin
         pus_in[a] = PUS_W'(s1_u_ff[a]) * PUS_W'(s1_s20_ff);
      end
   end

   always_comb begin
      cd   = SUM_W'(s2_c20_ff) <<< 28;
      sk_x = SUM_W'(pus_ff[AX]) <<< 14;
      sk_y = SUM_W'(pus_ff[AY]) <<< 14;
      sk_z = SUM_W'(pus_ff[AZ]) <<< 14;
      sum_in[0] = SUM_W'(puv_ff[XX]) + cd + ROUND_Q48;
      sum_in[1] = SUM_W'(puv_ff[XY]) - sk_z + ROUND_Q48;
      sum_in[2] = SUM_W'(puv_ff[XZ]) + sk_y + ROUND_Q48;
      sum_in[3] = SUM_W'(puv_ff[XY]) + sk_z + ROUND_Q48;
      sum_in[4] = SUM_W'(puv_ff[YY]) + cd + ROUND_Q48;
      sum_in[5] = SUM_W'(puv_ff[YZ]) - sk_x + ROUND_Q48;
      sum_in[6] = SUM_W'(puv_ff[XZ]) - sk_y + ROUND_Q48;
      sum_in[7] = SUM_W'(puv_ff[YZ]) + sk_x + ROUND_Q48;
      sum_in[8] = SUM_W'(puv_ff[ZZ]) + cd + ROUND_Q48;
   end

   always_comb begin
      rnd = '0;
      for (int e = 0; e < 9; e++) begin
         rnd = RND_W'(sum_ff[e] >>> 34);
         if (rnd > RND_W'(ENT_MAX)) begin
            ent_in[e] = ENT_MAX;
         end else if (rnd < RND_W'(ENT_MIN)) begin
            ent_in[e] = ENT_MIN;
         end else begin
            ent_in[e] = ENT_W'(rnd);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0] && in_valid) begin
         s1_c20_ff   <= c20_in;
         s1_s20_ff   <= s20_in;
         s1_v20_ff   <= v20_in;
         uu_ff       <= uu_in;
         s1_u_ff[AX] <= in_data.axis.x;
         s1_u_ff[AY] <= in_data.axis.y;
         s1_u_ff[AZ] <= in_data.axis.z;
      end
      if (ready[1] && valid_ff[0]) begin
         puv_ff    <= puv_in;
         pus_ff    <= pus_in;
         s2_c20_ff <= s1_c20_ff;
      end
      if (ready[2] && valid_ff[1]) begin
         sum_ff <= sum_in;
      end
      if (ready[3] && valid_ff[2]) begin
         ent_ff <= ent_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign ent       = ent_ff;

endmodule

// ===== rtl/core/axis_angle_to_rotation_matrix.sv =====
// Top level of the axis-angle to rotation matrix converter (Rodrigues' formula).
// Depends on a2rm_pkg, a2rm_reduce, a2rm_cordic_stage and a2rm_matrix.
//
//   Channel   Direction  Handshake             Word
//   req_      in         req_valid/req_stall   angle (Q3.14 rad), axis_x/y/z (Q1.14)
//   rsp_      out        rsp_valid/rsp_stall   m00..m22, row-major matrix in Q1.14
//
// A request passes through angle reduction, one registered stage per CORDIC micro-rotation and
// matrix assembly, in that order.
// One word enters and one leaves every cycle while the result side is not stalled.
// Every stage has its own valid bit and loads whenever it is empty or the stage after it
// moves, so a stall on the result side fills bubbles first before it reaches req_stall.
// Reset is synchronous and clears only the valid bits; data registers are not reset.
module axis_angle_to_rotation_matrix #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [a2rm_pkg::ANGLE_W-1:0] req_angle,
   input  logic signed [a2rm_pkg::AXIS_W-1:0]  req_axis_x,
   input  logic signed [a2rm_pkg::AXIS_W-1:0]  req_axis_y,
   input  logic signed [a2rm_pkg::AXIS_W-1:0]  req_axis_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [a2rm_pkg::ENT_W-1:0]   rsp_m00,
   output logic signed [a2rm_pkg::ENT_W-1:0]   rsp_m01,
   output logic signed [a2rm_pkg::ENT_W-1:0]   rsp_m02,
   output logic signed [a2rm_pkg::ENT_W-1:0]   rsp_m10,
   output logic signed [a2rm_pkg::ENT_W-1:0]   rsp_m11,
   output logic signed [a2rm_pkg::ENT_W-1:0]   rsp_m12,
   output logic signed [a2rm_pkg::ENT_W-1:0]   rsp_m20,
   output logic signed [a2rm_pkg::ENT_W-1:0]   rsp_m21,
   output logic signed [a2rm_pkg::ENT_W-1:0]   rsp_m22
);
   import a2rm_pkg::*;

   // The rotation chain: entry 0 is the output of range reduction, entry k the output of
   // micro-rotation k-1. Ready flows backward along the same chain.
   axis_type            req_axis;
   cordic_type          chain_data  [CORDIC_STAGES+1];
   logic [CORDIC_STAGES:0] chain_valid, chain_ready;
   logic                red_ready;
   logic signed [ENT_W-1:0] ent [9];

   assign req_axis.x = req_axis_x;
   assign req_axis.y = req_axis_y;
   assign req_axis.z = req_axis_z;

   // The input side stalls only when the reduction stage is full and cannot drain.
   assign req_stall = !red_ready;

   a2rm_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (red_ready),
      .angle     (req_angle),
      .axis      (req_axis),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   // One pipelined micro-rotation per stage; stage k shifts by k.
   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
      a2rm_cordic_stage #(
         .SHIFT (k)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_data   (chain_data[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_data  (chain_data[k+1])
      );
   end

   // Quadrant fold, Rodrigues products and the result register.
   a2rm_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[CORDIC_STAGES]),
      .in_ready  (chain_ready[CORDIC_STAGES]),
      .in_data   (chain_data[CORDIC_STAGES]),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .ent       (ent)
   );

   assign rsp_m00 = ent[0];
   assign rsp_m01 = ent[1];
   assign rsp_m02 = ent[2];
   assign rsp_m10 = ent[3];
   assign rsp_m11 = ent[4];
   assign rsp_m12 = ent[5];
   assign rsp_m20 = ent[6];
   assign rsp_m21 = ent[7];
   assign rsp_m22 = ent[8];

   // Reset empties the result register by the next edge.
   a_reset_empties : assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // The reduction must leave a residual the CORDIC can converge on.
   a_residual_range : assert property (@(posedge clock) disable iff (reset)
      chain_valid[0] |-> ($signed(chain_data[0].z) <= Q30_QUARTER_PI &&
                          $signed(chain_data[0].z) >= -Q30_QUARTER_PI))
      else $error("reduced angle outside quarter pi");

   // Saturation bounds the delivered diagonal samples m00 and m22 and off-diagonal m01 and m12.
   a_entries_saturated : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_m00 <= ENT_MAX && rsp_m00 >= ENT_MIN &&
                     rsp_m01 <= ENT_MAX && rsp_m01 >= ENT_MIN &&
                     rsp_m12 <= ENT_MAX && rsp_m12 >= ENT_MIN &&
                     rsp_m22 <= ENT_MAX && rsp_m22 >= ENT_MIN))
      else $error("matrix entry beyond saturation bound");

endmodule
